// ----- src/mqsb_pkg.sv -----
package mqsb_pkg;

  localparam int SLOTS  = 256;
  localparam int QUEUES = 8;

  localparam int SLOT_W = $clog2(SLOTS);
  // one more bit than a slot index, so that SLOTS itself serves as the null pointer
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QID_W  = 3;
  localparam int DATA_W = 32;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_FILL,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fill;
    logic out_comb;
    logic hold_load;
    logic out_hold;
  } mqsb_cmd_t;

  typedef struct packed {
    logic need_fetch;
    logic out_free;
  } mqsb_sts_t;

endpackage

// ----- src/mqsb_ram.sv -----
module mqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mqsb_ctrl.sv -----
module mqsb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mqsb_pkg::mqsb_sts_t sts,
  output mqsb_pkg::mqsb_cmd_t cmd
);

  mqsb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqsb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mqsb_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = mqsb_pkg::S_EXEC;
        end
      end
      mqsb_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_fetch) begin
          state_nxt = mqsb_pkg::S_FETCH;
        end else if (sts.out_free) begin
          cmd.out_comb = 1'b1;
          state_nxt    = mqsb_pkg::S_IDLE;
        end else begin
          cmd.hold_load = 1'b1;
          state_nxt     = mqsb_pkg::S_HOLD;
        end
      end
      // new head is known only after the link read, so its data needs one more read
      mqsb_pkg::S_FETCH: begin
        state_nxt = mqsb_pkg::S_FILL;
      end
      mqsb_pkg::S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.out_free) begin
          cmd.out_comb = 1'b1;
          state_nxt    = mqsb_pkg::S_IDLE;
        end else begin
          cmd.hold_load = 1'b1;
          state_nxt     = mqsb_pkg::S_HOLD;
        end
      end
      mqsb_pkg::S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_hold = 1'b1;
          state_nxt    = mqsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mqsb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/mqsb_dp.sv -----
module mqsb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mqsb_pkg::mqsb_cmd_t                 cmd,
  output mqsb_pkg::mqsb_sts_t                 sts,
  input  logic [1:0]                          in_mode,
  input  logic [mqsb_pkg::QID_W-1:0]          in_queue_id,
  input  logic signed [mqsb_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [mqsb_pkg::DATA_W-1:0]  out_front_value,
  output logic                                out_queue_empty
);

  localparam int PW = mqsb_pkg::PTR_W;
  localparam int SW = mqsb_pkg::SLOT_W;
  localparam int DW = mqsb_pkg::DATA_W;
  localparam int QW = mqsb_pkg::QIDX_W;

  // item registers
  logic [1:0]                 mode_r;
  logic [mqsb_pkg::QID_W-1:0] qid_r;
  logic signed [DW-1:0]       val_r;

  // queue and free-list pointers
  logic [PW-1:0] head_r [mqsb_pkg::QUEUES];
  logic [PW-1:0] tail_r [mqsb_pkg::QUEUES];
  logic [PW-1:0] free_r;
  // slots at and above this mark were never handed out; their link is simply slot + 1
  logic [PW-1:0] fresh_r;

  // output side
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic signed [DW-1:0] out_front_r;
  logic                 out_empty_r;
  logic [1:0]           hold_status_r;
  logic signed [DW-1:0] hold_front_r;
  logic                 hold_empty_r;

  // memories
  logic          data_we;
  logic [SW-1:0] data_waddr;
  logic [SW-1:0] data_raddr;
  logic [DW-1:0] data_rdata;
  logic          link_we;
  logic [SW-1:0] link_waddr;
  logic [SW-1:0] link_raddr;
  logic [PW-1:0] link_rdata;

  logic [mqsb_pkg::QID_W-1:0] rd_qid;
  logic [QW-1:0]              rd_qidx;
  logic [QW-1:0]              qidx;
  logic                       q_ok;
  logic [PW-1:0]              head_sel;
  logic [PW-1:0]              tail_q;
  logic                       head_ok;
  logic                       free_ok;
  logic [PW-1:0]              after;
  logic [PW-1:0]              next_head;
  logic                       is_push;
  logic                       is_pop;
  logic                       do_push;
  logic                       do_pop;

  logic [1:0]           res_status;
  logic signed [DW-1:0] res_front;
  logic                 res_empty;

  assign rd_qid   = cmd.accept ? in_queue_id : qid_r;
  assign rd_qidx  = QW'(rd_qid);
  assign qidx     = QW'(qid_r);
  assign q_ok     = 32'(qid_r) < 32'(mqsb_pkg::QUEUES);
  assign head_sel = head_r[rd_qidx];
  assign tail_q   = tail_r[qidx];
  assign head_ok  = head_sel < mqsb_pkg::NIL;
  assign free_ok  = free_r < mqsb_pkg::NIL;

  assign is_push = (mode_r == mqsb_pkg::MODE_PUSH);
  assign is_pop  = (mode_r == mqsb_pkg::MODE_POP);
  assign do_push = cmd.exec && q_ok && is_push && free_ok;
  assign do_pop  = cmd.exec && q_ok && is_pop && head_ok;

  assign after     = (free_r == fresh_r) ? fresh_r + PW'(1) : link_rdata;
  // a non-empty queue always has a correct tail, so the last element needs no null link
  assign next_head = (head_sel == tail_q) ? mqsb_pkg::NIL : link_rdata;

  assign data_raddr = head_sel[SW-1:0];
  assign link_raddr = (cmd.accept && in_mode == mqsb_pkg::MODE_PUSH) ? free_r[SW-1:0]
                                                                      : head_sel[SW-1:0];
  assign data_we    = do_push;
  assign data_waddr = free_r[SW-1:0];
  assign link_we    = (do_push && head_ok) || do_pop;
  assign link_waddr = is_push ? tail_q[SW-1:0] : head_sel[SW-1:0];

  mqsb_ram #(
    .WIDTH (DW),
    .DEPTH (mqsb_pkg::SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (val_r),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  mqsb_ram #(
    .WIDTH (PW),
    .DEPTH (mqsb_pkg::SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (free_r),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  always_comb begin
    res_status     = mqsb_pkg::ST_DONE;
    res_front      = '0;
    res_empty      = 1'b1;
    sts.need_fetch = 1'b0;
    sts.out_free   = !out_valid_r || out_ready;
    if (cmd.fill) begin
      res_front = data_rdata;
      res_empty = 1'b0;
    end else if (!q_ok) begin
      if (is_push) begin
        res_status = mqsb_pkg::ST_FULL;
      end else if (is_pop) begin
        res_status = mqsb_pkg::ST_EMPTY;
      end
    end else if (is_push) begin
      if (!free_ok) begin
        res_status = mqsb_pkg::ST_FULL;
      end
      if (head_ok) begin
        res_front = data_rdata;
        res_empty = 1'b0;
      end else if (free_ok) begin
        res_front = val_r;
        res_empty = 1'b0;
      end
    end else if (is_pop) begin
      if (!head_ok) begin
        res_status = mqsb_pkg::ST_EMPTY;
      end else if (next_head < mqsb_pkg::NIL) begin
        sts.need_fetch = cmd.exec;
      end
    end else if (head_ok) begin
      res_front = data_rdata;
      res_empty = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      qid_r  <= in_queue_id;
      val_r  <= in_value;
    end
    if (cmd.hold_load) begin
      hold_status_r <= res_status;
      hold_front_r  <= res_front;
      hold_empty_r  <= res_empty;
    end
    if (cmd.out_comb) begin
      out_status_r <= res_status;
      out_front_r  <= res_front;
      out_empty_r  <= res_empty;
    end else if (cmd.out_hold) begin
      out_status_r <= hold_status_r;
      out_front_r  <= hold_front_r;
      out_empty_r  <= hold_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
        head_r[i] <= mqsb_pkg::NIL;
        tail_r[i] <= mqsb_pkg::NIL;
      end
      free_r      <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_push) begin
        if (!head_ok) begin
          head_r[qidx] <= free_r;
        end
        tail_r[qidx] <= free_r;
        free_r       <= after;
        if (free_r == fresh_r) begin
          fresh_r <= fresh_r + PW'(1);
        end
      end else if (do_pop) begin
        head_r[qidx] <= next_head;
        free_r       <= head_sel;
      end
      if (cmd.out_comb || cmd.out_hold) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_queue_empty = out_empty_r;

endmodule

// ----- src/multi_queue_shared_buffer_unit.sv -----
// Eight FIFO queues share one store of 256 slots (data memory plus link memory); unused
// slots form a free list. Each input transaction pushes a value onto, pops the front of,
// or peeks at one queue and yields one result transaction with a status (done, store full
// on push, queue empty on pop) and the queue's front value and empty flag after the
// operation. One operation is in flight at a time. Push, peek and a pop that empties or
// finds an empty queue go from acceptance through the registered link/data memory reads
// to the pointer and link write-back, where the result is registered. A pop that leaves
// the queue non-empty then passes a fetch and a fill state, since the new front slot is
// known only after the link read and needs its own data memory read. The next transaction
// is taken as soon as the result is registered, even while it still waits on out_tready;
// a further result then waits in a holding register.
// Slots are handed out in order from a fresh-slot mark, so no memory clearing is needed
// after reset.
module multi_queue_shared_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[1:0], queue_id[4:2], value[36:5], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], front_value[33:2], queue_empty[34], zeros
);

  mqsb_pkg::mqsb_cmd_t cmd;
  mqsb_pkg::mqsb_sts_t sts;

  logic [1:0]                        out_status;
  logic signed [mqsb_pkg::DATA_W-1:0] out_front_value;
  logic                              out_queue_empty;

  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mqsb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_tdata[1:0]),
    .in_queue_id     (in_tdata[4:2]),
    .in_value        (in_tdata[36:5]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_queue_empty (out_queue_empty)
  );

  assign out_tdata = {5'b0, out_queue_empty, out_front_value, out_status};

  // one item at a time: an accepted transaction blocks input for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an operation is in flight");

  // an empty pop must report an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == mqsb_pkg::ST_EMPTY |-> out_tdata[34])
    else $error("empty status with non-empty queue flag");

  // an empty queue has no front value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[33:2] == '0)
    else $error("front value nonzero on empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= mqsb_pkg::ST_EMPTY && out_tdata[39:35] == '0)
    else $error("bad result encoding");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, behaves as a peek
  localparam int PHASE_OPS = 440;
  localparam int FILL_OPS = 270;
  localparam int DRAIN_OPS = 90;
  localparam int SW = mqsb_pkg::SLOT_W;

  typedef struct packed {
    logic [1:0]                  status;
    logic [mqsb_pkg::DATA_W-1:0] front;
    logic                        empty;
  } op_result_t;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [2:0]                  qid;
    logic [mqsb_pkg::DATA_W-1:0] val;
    logic                        typed;
    op_result_t                  res;
  } directed_op_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  // shadow copy of the slot store, link words and queue pointers
  logic [mqsb_pkg::DATA_W-1:0] slot_value [mqsb_pkg::SLOTS];
  logic [mqsb_pkg::PTR_W-1:0]  slot_next [mqsb_pkg::SLOTS];
  logic [mqsb_pkg::PTR_W-1:0]  q_first [mqsb_pkg::QUEUES];
  logic [mqsb_pkg::PTR_W-1:0]  q_last [mqsb_pkg::QUEUES];
  logic [mqsb_pkg::PTR_W-1:0]  free_first;

  op_result_t   expected_results[$];
  directed_op_t directed_ops[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int done_ops = 0;
  int full_pushes = 0;
  int empty_pops = 0;

  always #5 clk = ~clk;

  multi_queue_shared_buffer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic op_result_t apply_queue_op(input logic [1:0] mode, input logic [2:0] qid,
                                                input logic [mqsb_pkg::DATA_W-1:0] val);
    op_result_t                 r;
    logic [mqsb_pkg::PTR_W-1:0] slot;
    logic [mqsb_pkg::PTR_W-1:0] after;
    r.status = mqsb_pkg::ST_DONE;
    r.front = '0;
    r.empty = 1'b1;
    if (qid >= mqsb_pkg::QUEUES) begin
      if (mode == mqsb_pkg::MODE_PUSH) begin
        r.status = mqsb_pkg::ST_FULL;
      end else if (mode == mqsb_pkg::MODE_POP) begin
        r.status = mqsb_pkg::ST_EMPTY;
      end
    end else begin
      if (mode == mqsb_pkg::MODE_PUSH) begin
        slot = free_first;
        if (slot >= mqsb_pkg::SLOTS) begin
          r.status = mqsb_pkg::ST_FULL;
        end else begin
          after = slot_next[slot[SW-1:0]];
          slot_value[slot[SW-1:0]] = val;
          slot_next[slot[SW-1:0]] = mqsb_pkg::NIL;
          if (q_first[qid] >= mqsb_pkg::SLOTS) begin
            q_first[qid] = slot;
          end else if (q_last[qid] < mqsb_pkg::SLOTS) begin
            slot_next[q_last[qid][SW-1:0]] = slot;
          end
          q_last[qid] = slot;
          free_first = after;
        end
      end else if (mode == mqsb_pkg::MODE_POP) begin
        slot = q_first[qid];
        if (slot >= mqsb_pkg::SLOTS) begin
          r.status = mqsb_pkg::ST_EMPTY;
        end else begin
          // popped slot goes back on the front of the free list; tail is left stale
          q_first[qid] = slot_next[slot[SW-1:0]];
          slot_next[slot[SW-1:0]] = free_first;
          free_first = slot;
        end
      end
      if (q_first[qid] < mqsb_pkg::SLOTS) begin
        r.front = slot_value[q_first[qid][SW-1:0]];
        r.empty = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic send_op(input logic [1:0] mode, input logic [2:0] qid,
                         input logic [mqsb_pkg::DATA_W-1:0] val, input logic typed,
                         input op_result_t typed_res);
    op_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, val, qid, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_queue_op(mode, qid, val);
    expected_results.push_back(typed ? typed_res : predicted);
    if (predicted.status == mqsb_pkg::ST_FULL) full_pushes++;
    else if (predicted.status == mqsb_pkg::ST_EMPTY) empty_pops++;
    else done_ops++;
  endtask

  always @(posedge clk) begin : result_check
    op_result_t want;
    op_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[33:2], out_tdata[34]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction status=%0d front=%h empty=%b",
                 $time, got.status, got.front, got.empty);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.front !== want.front ||
            got.empty !== want.empty) begin
          $display("%0t: mismatch expected status=%0d front=%h empty=%b,",
                   $time, want.status, want.front, want.empty,
                   " got status=%0d front=%h empty=%b",
                   got.status, got.front, got.empty);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    int         p;
    int         i;
    int         roll;
    logic [1:0] mode;
    logic [2:0] qid;
    logic [2:0] churn_q;

    for (i = 0; i < mqsb_pkg::SLOTS; i++) begin
      slot_value[i] = '0;
      slot_next[i] = mqsb_pkg::PTR_W'(i + 1);
    end
    slot_next[mqsb_pkg::SLOTS-1] = mqsb_pkg::NIL;
    for (i = 0; i < mqsb_pkg::QUEUES; i++) begin
      q_first[i] = mqsb_pkg::NIL;
      q_last[i] = mqsb_pkg::NIL;
    end
    free_first = '0;

    directed_ops.push_back({mqsb_pkg::MODE_PEEK, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b1});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd5, 32'h0, 1'b1,
                            mqsb_pkg::ST_EMPTY, 32'h0, 1'b1});
    directed_ops.push_back({MODE_SPARE, 3'd7, 32'hffffffff, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b1});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd0, 32'h7fffffff, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h7fffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd0, 32'h80000000, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h7fffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd7, 32'hffffffff, 1'b1,
                            mqsb_pkg::ST_DONE, 32'hffffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd7, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'hffffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_PEEK, 3'd0, 32'h5a5a5a5a, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h7fffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h80000000, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b1});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_EMPTY, 32'h0, 1'b1});
    // push onto a queue whose tail pointer is stale
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd0, 32'h12345678, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h12345678, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd0, 32'ha5a5a5a5, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h12345678, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'ha5a5a5a5, 1'b0});
    directed_ops.push_back({MODE_SPARE, 3'd7, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'hffffffff, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd7, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd7, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b1});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd3, 32'h0f0f0f0f, 1'b0, 35'h0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd3, 32'hf0f0f0f0, 1'b0, 35'h0});
    directed_ops.push_back({mqsb_pkg::MODE_PEEK, 3'd3, 32'h0, 1'b0, 35'h0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd3, 32'h0, 1'b0, 35'h0});
    directed_ops.push_back({mqsb_pkg::MODE_PUSH, 3'd6, 32'h00000001, 1'b0, 35'h0});
    directed_ops.push_back({mqsb_pkg::MODE_POP, 3'd0, 32'h0, 1'b1,
                            mqsb_pkg::ST_DONE, 32'h0, 1'b1});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[k]) begin
      send_op(directed_ops[k].mode, directed_ops[k].qid, directed_ops[k].val,
              directed_ops[k].typed, directed_ops[k].res);
    end

    // each phase fills the store toward full, drains part of it, then churns one queue
    for (p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 74 : (p == 3) ? 37 : 0;
      recv_stall_pct <= (p == 2) ? 74 : (p == 3) ? 37 : 0;
      churn_q = 3'($urandom_range(mqsb_pkg::QUEUES - 1));
      for (i = 0; i < PHASE_OPS; i++) begin
        roll = $urandom_range(99);
        qid = 3'($urandom_range(7));
        if (i < FILL_OPS) begin
          mode = (roll < 95) ? mqsb_pkg::MODE_PUSH :
                 (roll < 98) ? mqsb_pkg::MODE_POP : mqsb_pkg::MODE_PEEK;
        end else if (i < FILL_OPS + DRAIN_OPS) begin
          mode = (roll < 95) ? mqsb_pkg::MODE_POP :
                 (roll < 98) ? mqsb_pkg::MODE_PUSH : mqsb_pkg::MODE_PEEK;
        end else begin
          qid = churn_q;
          mode = (roll < 65) ? mqsb_pkg::MODE_POP :
                 (roll < 92) ? mqsb_pkg::MODE_PUSH : mqsb_pkg::MODE_PEEK;
        end
        if (mode == mqsb_pkg::MODE_PEEK && $urandom_range(1) == 1) mode = MODE_SPARE;
        send_op(mode, qid, $urandom(), 1'b0, 35'h0);
      end
    end
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d completed operations, %0d pushes on a full store,", done_ops,
             full_pushes, " %0d pops on empty queues", empty_pops);
    $display("directed extremes plus four handshake phases with sender gaps and receiver stalls");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
